// ----- src/vtt_pkg.sv -----
// shared constants and codes for the virtual timer table
`default_nettype none
package vtt_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int MODE_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int TIME_W     = 32;
    localparam int DUR_W      = 31;
    localparam int COUNT_W    = 5;
    localparam int MARGIN_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_START_PERIODIC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START_ONESHOT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CANCEL_ALL     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHECK          = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUE_MARGIN   = 1'd1;

    localparam logic [COUNT_W-1:0]  SLOTS_IN_USE_RESET = 5'd0;
    localparam logic [MARGIN_W-1:0] DUE_MARGIN_RESET   = 16'd10;
    localparam logic [TIME_W-1:0]   NONE_REMAINING     = 32'h7FFF_FFFF;

endpackage
`default_nettype wire

// ----- src/vtt_if.sv -----
// request and response channel interfaces of the virtual timer table
`default_nettype none
interface vtt_req_if;
    logic                         valid;
    logic                         ready;
    logic [vtt_pkg::MODE_W-1:0]   mode;
    logic [vtt_pkg::SLOT_W-1:0]   slot;
    logic [vtt_pkg::TIME_W-1:0]   now;
    logic [vtt_pkg::DUR_W-1:0]    duration;

    modport source (output valid, output mode, output slot, output now, output duration,
                    input ready);
    modport sink (input valid, input mode, input slot, input now, input duration,
                  output ready);
endinterface

interface vtt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic                              fired;
    logic [vtt_pkg::SLOT_W-1:0]        fired_slot;
    logic                              any_running;
    logic signed [vtt_pkg::TIME_W-1:0] least_remaining;
    logic                              due_soon;

    modport source (output valid, output status, output fired, output fired_slot,
                    output any_running, output least_remaining, output due_soon,
                    input ready);
    modport sink (input valid, input status, input fired, input fired_slot,
                  input any_running, input least_remaining, input due_soon,
                  output ready);
endinterface
`default_nettype wire

// ----- src/virtual_timer_table_top.sv -----
// virtual timer table: slot store, serial scan sequencer and shared adder
// scan: each slot in use is visited in turn; an idle slot is skipped in the read state and
// a running slot passes the read, elapsed, compare and minimum states; a periodic slot
// that fires adds the advance states and a one-shot slot that fires skips the minimum
// transactions: one at a time, the next accepted only once the result is registered,
// which waits while a previous response is still held
// reset: running and one-shot flags cleared, slots_in_use 0, due_margin 10
`default_nettype none
module virtual_timer_table_top #(
    parameter int SLOTS = vtt_pkg::SLOTS_DEFAULT
) (
    input  wire                              clk,
    input  wire                              rst_n,
    vtt_req_if.sink                          req,
    vtt_rsp_if.source                        rsp,
    input  wire                              cfg_we,
    input  wire [vtt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [vtt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int TW    = vtt_pkg::TIME_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EL   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_ADV1 = 3'd4;
    localparam logic [2:0] ST_ADV2 = 3'd5;
    localparam logic [2:0] ST_MIN  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [vtt_pkg::COUNT_W-1:0]     slots_in_use_reg;
    logic [vtt_pkg::MARGIN_W-1:0]    due_margin_reg;
    logic [SLOTS-1:0]                running_reg, running_next;
    logic [SLOTS-1:0]                one_shot_reg, one_shot_next;
    logic [vtt_pkg::MODE_W-1:0]      mode_reg, mode_next;
    logic [TW-1:0]                   now_reg, now_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [TW-1:0]                   elapsed_reg, elapsed_next;
    logic [TW-1:0]                   rem_reg, rem_next;
    logic [TW-1:0]                   minrem_reg, minrem_next;
    logic                            any_reg, any_next;
    logic                            fired_reg, fired_next;
    logic [vtt_pkg::SLOT_W-1:0]      fired_slot_reg, fired_slot_next;
    logic                            status_reg, status_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_status_reg, out_fired_reg, out_any_reg, out_due_reg;
    logic [vtt_pkg::SLOT_W-1:0]      out_fired_slot_reg;
    logic [TW-1:0]                   out_minrem_reg;

    logic [TW-1:0]                   start_mem [SLOTS];
    logic [vtt_pkg::DUR_W-1:0]       period_mem [SLOTS];
    logic [TW-1:0]                   rd_start_reg;
    logic [vtt_pkg::DUR_W-1:0]       rd_period_reg;

    logic [CNT_W-1:0]                count;
    logic [IDX_W-1:0]                req_idx;
    logic [IDX_W-1:0]                scan_idx;
    logic                            accept;
    logic                            slot_bad;
    logic                            start_we;
    logic                            adv_we;
    logic [32:0]                     add_a, add_b, add_sum;
    logic                            add_sub;
    logic                            expired;
    logic                            due_now;
    logic                            load_out;

    assign count = (32'(slots_in_use_reg) > 32'(SLOTS)) ? CNT_W'(SLOTS)
                                                          : CNT_W'(slots_in_use_reg);
    assign req_idx  = IDX_W'(req.slot);
    assign scan_idx = idx_reg[IDX_W-1:0];
    assign accept   = req.valid && req.ready;
    assign slot_bad = 32'(req.slot) >= 32'(count);
    assign start_we = accept && !slot_bad &&
                      (req.mode == vtt_pkg::MODE_START_PERIODIC ||
                       req.mode == vtt_pkg::MODE_START_ONESHOT);
    assign adv_we   = (state_reg == ST_ADV1);

    // shared adder
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_EL:
            begin
                add_a   = {1'b0, now_reg};
                add_b   = {1'b0, rd_start_reg};
                add_sub = 1'b1;
            end
            ST_CMP:
            begin
                add_a   = {2'b00, rd_period_reg};
                add_b   = {1'b0, elapsed_reg};
                add_sub = 1'b1;
            end
            ST_ADV1:
            begin
                add_a = {1'b0, rd_start_reg};
                add_b = {2'b00, rd_period_reg};
            end
            ST_ADV2:
            begin
                add_a = {1'b0, rem_reg};
                add_b = {2'b00, rd_period_reg};
            end
            ST_MIN:
            begin
                add_a   = {rem_reg[TW-1], rem_reg};
                add_b   = {minrem_reg[TW-1], minrem_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + {32'd0, add_sub};
    end

    assign expired  = add_sum[32] || (add_sum[TW-1:0] == '0);
    assign due_now  = any_reg &&
                      (minrem_reg[TW-1] || (minrem_reg <= {16'd0, due_margin_reg}));
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        one_shot_next   = one_shot_reg;
        mode_next       = mode_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        elapsed_next    = elapsed_reg;
        rem_next        = rem_reg;
        minrem_next     = minrem_reg;
        any_next        = any_reg;
        fired_next      = fired_reg;
        fired_slot_next = fired_slot_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = req.mode;
                    now_next        = req.now;
                    idx_next        = '0;
                    any_next        = 1'b0;
                    minrem_next     = vtt_pkg::NONE_REMAINING;
                    fired_next      = 1'b0;
                    fired_slot_next = '0;
                    status_next     = 1'b0;
                    case (req.mode)
                        vtt_pkg::MODE_START_PERIODIC, vtt_pkg::MODE_START_ONESHOT,
                        vtt_pkg::MODE_CANCEL:
                        begin
                            if (slot_bad)
                            begin
                                status_next = 1'b1;
                            end
                            else if (req.mode == vtt_pkg::MODE_CANCEL)
                            begin
                                running_next[req_idx] = 1'b0;
                            end
                            else
                            begin
                                running_next[req_idx]  = 1'b1;
                                one_shot_next[req_idx] =
                                    (req.mode == vtt_pkg::MODE_START_ONESHOT);
                            end
                        end
                        vtt_pkg::MODE_CANCEL_ALL:
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (32'(i) < 32'(count))
                                begin
                                    running_next[i] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = 1'b0;
                        end
                    endcase
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (idx_reg >= count)
                begin
                    state_next = ST_DONE;
                end
                else if (!running_reg[scan_idx])
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EL;
                end
            end
            ST_EL:
            begin
                elapsed_next = add_sum[TW-1:0];
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                rem_next = add_sum[TW-1:0];
                if (mode_reg == vtt_pkg::MODE_CHECK && !fired_reg && expired)
                begin
                    fired_next      = 1'b1;
                    fired_slot_next = vtt_pkg::SLOT_W'(idx_reg);
                    if (one_shot_reg[scan_idx])
                    begin
                        running_next[scan_idx] = 1'b0;
                        idx_next               = idx_reg + CNT_W'(1);
                        state_next             = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_ADV1;
                    end
                end
                else
                begin
                    state_next = ST_MIN;
                end
            end
            ST_ADV1:
            begin
                state_next = ST_ADV2;
            end
            ST_ADV2:
            begin
                rem_next   = add_sum[TW-1:0];
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                if (!any_reg || add_sum[32])
                begin
                    minrem_next = rem_reg;
                end
                any_next   = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_RD;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slots_in_use_reg <= vtt_pkg::SLOTS_IN_USE_RESET;
            due_margin_reg   <= vtt_pkg::DUE_MARGIN_RESET;
            running_reg      <= '0;
            one_shot_reg     <= '0;
            out_valid_reg    <= 1'b0;
            fired_reg        <= 1'b0;
            any_reg          <= 1'b0;
            idx_reg          <= '0;
            mode_reg         <= vtt_pkg::MODE_CHECK;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            one_shot_reg  <= one_shot_next;
            out_valid_reg <= out_valid_next;
            fired_reg     <= fired_next;
            any_reg       <= any_next;
            idx_reg       <= idx_next;
            mode_reg      <= mode_next;
            if (cfg_we)
            begin
                if (cfg_index == vtt_pkg::CFG_SLOTS_IN_USE)
                begin
                    slots_in_use_reg <= cfg_data[vtt_pkg::COUNT_W-1:0];
                end
                else if (cfg_index == vtt_pkg::CFG_DUE_MARGIN)
                begin
                    due_margin_reg <= cfg_data;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        elapsed_reg    <= elapsed_next;
        rem_reg        <= rem_next;
        minrem_reg     <= minrem_next;
        fired_slot_reg <= fired_slot_next;
        status_reg     <= status_next;
        if (load_out)
        begin
            out_status_reg     <= status_reg;
            out_fired_reg      <= fired_reg;
            out_fired_slot_reg <= fired_slot_reg;
            out_any_reg        <= any_reg;
            out_minrem_reg     <= minrem_reg;
            out_due_reg        <= due_now;
        end
    end

    // slot store
    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[req_idx]  <= req.now;
            period_mem[req_idx] <= req.duration;
        end
        else if (adv_we)
        begin
            start_mem[scan_idx] <= add_sum[TW-1:0];
        end
        rd_start_reg  <= start_mem[scan_idx];
        rd_period_reg <= period_mem[scan_idx];
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.fired           = out_fired_reg;
    assign rsp.fired_slot      = out_fired_slot_reg;
    assign rsp.any_running     = out_any_reg;
    assign rsp.least_remaining = $signed(out_minrem_reg);
    assign rsp.due_soon        = out_due_reg;

    a_fire_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        fired_reg |-> mode_reg == vtt_pkg::MODE_CHECK)
        else $error("fire outside a check");

    a_fire_from_compare: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fired_reg) |-> $past(state_reg) == ST_CMP)
        else $error("fire not raised by the expiry compare");

    a_idle_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.any_running) |->
            (out_minrem_reg == vtt_pkg::NONE_REMAINING && !rsp.due_soon))
        else $error("summary without running slots is not the idle value");

    a_bad_slot_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status) |-> !rsp.fired)
        else $error("rejected slot reported a fire");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_RD && state_reg != ST_DONE) |->
            idx_reg < count)
        else $error("scan index beyond slots in use");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for the virtual timer table, with a behavioural slot table model
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = vtt_pkg::SLOTS_DEFAULT;
    localparam int MODE_W      = vtt_pkg::MODE_W;
    localparam int SLOT_W      = vtt_pkg::SLOT_W;
    localparam int TIME_W      = vtt_pkg::TIME_W;
    localparam int DUR_W       = vtt_pkg::DUR_W;
    localparam int COUNT_W     = vtt_pkg::COUNT_W;
    localparam int MARGIN_W    = vtt_pkg::MARGIN_W;
    localparam int CFG_IDX_W   = vtt_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = vtt_pkg::CFG_DATA_W;
    localparam int STALL_LIMIT = 4000;
    localparam int SCAN_CYCLES = 80;
    localparam int REPORT_MAX  = 10;
    localparam int PHASE_ITEMS = 240;

    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;
    localparam logic [DUR_W-1:0]  DUR_MAX           = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
        logic [DUR_W-1:0]  duration;
    } timer_op_t;

    typedef struct packed {
        logic                     status;
        logic                     fired;
        logic [SLOT_W-1:0]        fired_slot;
        logic                     any_running;
        logic signed [TIME_W-1:0] least_remaining;
        logic                     due_soon;
    } timer_summary_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vtt_req_if req_bus ();
    vtt_rsp_if rsp_bus ();

    virtual_timer_table_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [TIME_W-1:0]   slot_start    [NUM_SLOTS];
    logic [DUR_W-1:0]    slot_period   [NUM_SLOTS];
    logic                slot_running  [NUM_SLOTS];
    logic                slot_one_shot [NUM_SLOTS];
    logic [COUNT_W-1:0]  slots_in_use;
    logic [MARGIN_W-1:0] due_margin;

    timer_summary_t pending_summaries [$];
    int             mismatch_count  = 0;
    int             rsp_hold_cycles = 0;
    bit             idling_on       = 1'b1;
    logic [TIME_W-1:0] tick;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int slots_active();
        return (slots_in_use > NUM_SLOTS) ? NUM_SLOTS : int'(slots_in_use);
    endfunction

    function automatic timer_summary_t compute_timer_summary(input timer_op_t op);
        timer_summary_t    s;
        int                count;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] rem;
        s = '0;
        s.least_remaining = vtt_pkg::NONE_REMAINING;
        count = slots_active();
        case (op.mode)
            vtt_pkg::MODE_START_PERIODIC, vtt_pkg::MODE_START_ONESHOT, vtt_pkg::MODE_CANCEL:
            begin
                if (op.slot >= count)
                    s.status = 1'b1;
                else if (op.mode == vtt_pkg::MODE_CANCEL)
                    slot_running[op.slot] = 1'b0;
                else
                begin
                    slot_running[op.slot]  = 1'b1;
                    slot_one_shot[op.slot] = (op.mode == vtt_pkg::MODE_START_ONESHOT);
                    slot_start[op.slot]    = op.now;
                    slot_period[op.slot]   = op.duration;
                end
            end
            vtt_pkg::MODE_CANCEL_ALL:
            begin
                for (int i = 0; i < count; i++)
                    slot_running[i] = 1'b0;
            end
            vtt_pkg::MODE_CHECK:
            begin
                for (int i = 0; i < count && s.fired == 1'b0; i++)
                begin
                    elapsed = op.now - slot_start[i];
                    if (slot_running[i] && elapsed >= {1'b0, slot_period[i]})
                    begin
                        if (slot_one_shot[i])
                            slot_running[i] = 1'b0;
                        else
                            slot_start[i] = slot_start[i] + {1'b0, slot_period[i]};
                        s.fired      = 1'b1;
                        s.fired_slot = SLOT_W'(i);
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < count; i++)
        begin
            if (slot_running[i])
            begin
                rem = {1'b0, slot_period[i]} - (op.now - slot_start[i]);
                if (!s.any_running || $signed(rem) < s.least_remaining)
                    s.least_remaining = rem;
                s.any_running = 1'b1;
            end
        end
        s.due_soon = s.any_running &&
                     (s.least_remaining <= $signed({16'b0, due_margin}));
        return s;
    endfunction

    function automatic timer_op_t make_op(input logic [MODE_W-1:0] mode,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [TIME_W-1:0] now,
                                          input logic [DUR_W-1:0]  duration);
        timer_op_t op;
        op.mode     = mode;
        op.slot     = slot;
        op.now      = now;
        op.duration = duration;
        return op;
    endfunction

    function automatic timer_op_t random_op();
        timer_op_t op;
        int        pick;
        int        count;
        count = slots_active();
        pick  = $urandom_range(0, 99);
        if (pick < 20)
            op.mode = vtt_pkg::MODE_START_PERIODIC;
        else if (pick < 35)
            op.mode = vtt_pkg::MODE_START_ONESHOT;
        else if (pick < 45)
            op.mode = vtt_pkg::MODE_CANCEL;
        else if (pick < 48)
            op.mode = vtt_pkg::MODE_CANCEL_ALL;
        else if (pick < 95)
            op.mode = vtt_pkg::MODE_CHECK;
        else
            op.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        if (count > 0 && $urandom_range(0, 9) != 0)
            op.slot = SLOT_W'($urandom_range(0, count - 1));
        else
            op.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        if ($urandom_range(0, 99) < 3)
            tick = $urandom;
        else
            tick = tick + $urandom_range(0, 30);
        op.now = ($urandom_range(0, 49) == 0) ? $urandom : tick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            op.duration = DUR_W'($urandom_range(0, 120));
        else if (pick < 85)
            op.duration = DUR_W'($urandom);
        else if (pick < 95)
            op.duration = DUR_W'($urandom_range(0, 4));
        else
            op.duration = DUR_MAX;
        return op;
    endfunction

    task automatic send_op(input timer_op_t op);
        @(negedge clk);
        req_bus.valid    = 1'b1;
        req_bus.mode     = op.mode;
        req_bus.slot     = op.slot;
        req_bus.now      = op.now;
        req_bus.duration = op.duration;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        pending_summaries.push_back(compute_timer_summary(op));
    endtask

    task automatic req_pause(input int cycles);
        @(negedge clk);
        req_bus.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_for_summaries();
        req_pause(1);
        while (pending_summaries.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_for_summaries();
        repeat (2) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == vtt_pkg::CFG_SLOTS_IN_USE)
            slots_in_use = COUNT_W'(value);
        else
            due_margin = MARGIN_W'(value);
    endtask

    task automatic configure(input int unsigned slots, input int unsigned margin);
        write_reg(vtt_pkg::CFG_SLOTS_IN_USE, slots);
        write_reg(vtt_pkg::CFG_DUE_MARGIN, margin);
    endtask

    task automatic check_summary();
        timer_summary_t seen;
        timer_summary_t want;
        seen.status          = rsp_bus.status;
        seen.fired           = rsp_bus.fired;
        seen.fired_slot      = rsp_bus.fired_slot;
        seen.any_running     = rsp_bus.any_running;
        seen.least_remaining = rsp_bus.least_remaining;
        seen.due_soon        = rsp_bus.due_soon;
        if (pending_summaries.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("unexpected response transaction: rem=%0d", seen.least_remaining);
        end
        else
        begin
            want = pending_summaries.pop_front();
            if (seen.status !== want.status || seen.fired !== want.fired ||
                seen.fired_slot !== want.fired_slot ||
                seen.any_running !== want.any_running ||
                seen.least_remaining !== want.least_remaining ||
                seen.due_soon !== want.due_soon)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("mismatch: expected st=%0b fi=%0b fs=%0d run=%0b rem=%0d due=%0b,",
                             want.status, want.fired, want.fired_slot, want.any_running,
                             want.least_remaining, want.due_soon,
                             " got st=%0b fi=%0b fs=%0d run=%0b rem=%0d due=%0b",
                             seen.status, seen.fired, seen.fired_slot, seen.any_running,
                             seen.least_remaining, seen.due_soon);
            end
        end
    endtask

    // response side: random stalls plus an optional long hold-off
    initial
    begin
        int stall_left;
        stall_left    = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_bus.ready = 1'b0;
                rsp_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_bus.ready = 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                rsp_bus.ready = 1'b0;
                stall_left    = $urandom_range(0, 5);
            end
            else
                rsp_bus.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_summary();
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_reset_defaults();
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd0, tick, 31'd5));
        send_op(make_op(vtt_pkg::MODE_CHECK, 4'd0, tick, 31'd0));
    endtask

    task automatic test_directed_cases();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FFF0;
        configure(NUM_SLOTS, 10);
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd0, t0, 31'd0));
        send_op(make_op(vtt_pkg::MODE_CHECK, 4'd0, t0, 31'd0));
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd15, t0, DUR_MAX));
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd2, t0, 31'd20));
        // periodic restart must drop the one-shot flag
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd2, t0, 31'd20));
        send_op(make_op(vtt_pkg::MODE_CANCEL, 4'd0, t0 + 32'd25, 31'd0));
        send_op(make_op(vtt_pkg::MODE_CHECK, 4'd0, t0 + 32'd25, 31'd0));
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd5, t0 + 32'd45, 31'd3));
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd6, t0 + 32'd45, 31'd1));
        repeat (5) send_op(make_op(vtt_pkg::MODE_CHECK, 4'd0, t0 + 32'd100, 31'd0));
        send_op(make_op(MODE_UNUSED_FIRST, 4'd15, '1, DUR_MAX));
        send_op(make_op(MODE_UNUSED_LAST, 4'd0, '0, '0));
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd8, '0, 31'd1000));
        // cancel all only reaches the slots in use
        write_reg(vtt_pkg::CFG_SLOTS_IN_USE, 4);
        send_op(make_op(vtt_pkg::MODE_CANCEL_ALL, 4'd9, '0, 31'd0));
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd4, '0, 31'd7));
        send_op(make_op(vtt_pkg::MODE_CANCEL, 4'd15, '0, 31'd0));
        write_reg(vtt_pkg::CFG_SLOTS_IN_USE, NUM_SLOTS);
        send_op(make_op(vtt_pkg::MODE_CHECK, 4'd0, '0, 31'd0));
    endtask

    task automatic test_slot_count_limits();
        configure(31, 65535);
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd15, '1, 31'd0));
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd15, '0, DUR_MAX));
        send_op(make_op(vtt_pkg::MODE_CANCEL_ALL, 4'd0, '0, 31'd0));
        configure(0, 0);
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd0, '0, 31'd0));
        configure(1, 0);
        send_op(make_op(vtt_pkg::MODE_START_PERIODIC, 4'd0, 32'd5, 31'd0));
        send_op(make_op(vtt_pkg::MODE_START_ONESHOT, 4'd1, 32'd5, 31'd0));
        send_op(make_op(vtt_pkg::MODE_CANCEL, 4'd0, 32'd5, 31'd0));
    endtask

    task automatic run_random_ops(input int count);
        repeat (count)
        begin
            if (idling_on && $urandom_range(0, 7) == 0)
                req_pause($urandom_range(1, 6));
            send_op(random_op());
        end
    endtask

    task automatic test_random_settings();
        int unsigned slot_set   [7] = '{16, 4, 1, 31, 0, 8, 16};
        int unsigned margin_set [7] = '{10, 0, 65535, 100, 10, 3000, 0};
        margin_set[6] = $urandom_range(0, 65535);
        for (int p = 0; p < 7; p++)
        begin
            configure(slot_set[p], margin_set[p]);
            run_random_ops(PHASE_ITEMS);
        end
    endtask

    task automatic test_response_hold();
        configure(NUM_SLOTS, 50);
        send_op(random_op());
        rsp_hold_cycles = 300;
        repeat (8) send_op(random_op());
    endtask

    task automatic test_sender_pause();
        wait_for_summaries();
        req_pause($urandom_range(1, 6));
        run_random_ops(20);
    endtask

    task automatic test_unstalled_finish();
        wait_for_summaries();
        idling_on = 1'b0;
        configure(NUM_SLOTS, 20);
        run_random_ops(150);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = vtt_pkg::CFG_SLOTS_IN_USE;
        cfg_data         = '0;
        req_bus.valid    = 1'b0;
        req_bus.mode     = vtt_pkg::MODE_CHECK;
        req_bus.slot     = '0;
        req_bus.now      = '0;
        req_bus.duration = '0;
        slots_in_use     = vtt_pkg::SLOTS_IN_USE_RESET;
        due_margin       = vtt_pkg::DUE_MARGIN_RESET;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_start[i]    = '0;
            slot_period[i]   = '0;
            slot_running[i]  = 1'b0;
            slot_one_shot[i] = 1'b0;
        end
        tick = $urandom;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_slot_count_limits();
        test_random_settings();
        test_response_hold();
        test_sender_pause();
        test_unstalled_finish();

        wait_for_summaries();
        repeat (SCAN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_summaries.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
